/* design/pdcfs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants of the density and current Fourier sum block.
// No dependencies; every other file but pdcfs_chk imports this package.
package pdcfs_pkg;

    localparam int unsigned MAX_PARTICLES_DEF = 4096;

    localparam int FIELD_W   = 24;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int SCALE_W   = 24;
    localparam int OUT_W     = 48;
    localparam int ACC_W     = 48;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int TRIG_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_OUT   = 8;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0] COEF_A9 = 32'd172272;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT   = 2'd0,
        CFG_SCALE   = 2'd1,
        CFG_CURRENT = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef struct packed {
        logic [CNT_W-1:0]   particle_count;
        logic [SCALE_W-1:0] scale_factor;
        logic               with_current;
    } t_cfg;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
        logic signed [FIELD_W-1:0] vel_x;
        logic signed [FIELD_W-1:0] vel_y;
        logic signed [FIELD_W-1:0] vel_z;
    } t_part;

    // Horner coefficients after A9, in order of use
    function automatic logic [31:0] f_horner(input logic [1:0] k);
        logic [31:0] v;
        case (k)
            2'd0:    v = 32'd5026995;
            2'd1:    v = 32'd85569306;
            2'd2:    v = 32'd693598668;
            default: v = 32'd1686629713;
        endcase
        return v;
    endfunction

endpackage

/* design/pdcfs_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input items and the result items.
// Depends on pdcfs_pkg.
interface pdcfs_in_if;
    import pdcfs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [IDX_W-1:0]          particle_index;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic signed [FIELD_W-1:0] vel_z;
    logic signed [FIELD_W-1:0] wave_x;
    logic signed [FIELD_W-1:0] wave_y;
    logic signed [FIELD_W-1:0] wave_z;

    modport source (output valid, kind, particle_index, pos_x, pos_y, pos_z,
                    vel_x, vel_y, vel_z, wave_x, wave_y, wave_z, input ready);
    modport sink   (input valid, kind, particle_index, pos_x, pos_y, pos_z,
                    vel_x, vel_y, vel_z, wave_x, wave_y, wave_z, output ready);
endinterface

interface pdcfs_out_if;
    import pdcfs_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] density_re;
    logic signed [OUT_W-1:0] density_im;
    logic signed [OUT_W-1:0] current_x_re;
    logic signed [OUT_W-1:0] current_x_im;
    logic signed [OUT_W-1:0] current_y_re;
    logic signed [OUT_W-1:0] current_y_im;
    logic signed [OUT_W-1:0] current_z_re;
    logic signed [OUT_W-1:0] current_z_im;
    logic                    saturated;

    modport source (output valid, density_re, density_im, current_x_re, current_x_im,
                    current_y_re, current_y_im, current_z_re, current_z_im, saturated,
                    input ready);
    modport sink   (input valid, density_re, density_im, current_x_re, current_x_im,
                    current_y_re, current_y_im, current_z_re, current_z_im, saturated,
                    output ready);
endinterface

/* design/pdcfs_mul.sv */
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on pdcfs_pkg.
module pdcfs_mul (
    input  logic                             i_clk,
    input  logic signed [pdcfs_pkg::MUL_W-1:0]  i_a,
    input  logic signed [pdcfs_pkg::MUL_W-1:0]  i_b,
    output logic signed [pdcfs_pkg::PROD_W-1:0] o_prod
);
    import pdcfs_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

/* design/pdcfs_store.sv */
`timescale 1ns / 1ps
// Particle store: positions and velocities, one write and one registered read.
// Depends on pdcfs_pkg.
module pdcfs_store #(
    parameter int unsigned DEPTH = pdcfs_pkg::MAX_PARTICLES_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  pdcfs_pkg::t_part i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output pdcfs_pkg::t_part o_rdata
);
    import pdcfs_pkg::*;

    t_part r_mem [DEPTH];
    t_part r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/pdcfs_seq.sv */
`timescale 1ns / 1ps
// Sequencer and datapath: phase, quarter-wave sine polynomial, current terms and
// output scaling, all through one shared multiplier. Depends on pdcfs_pkg, pdcfs_if.
module pdcfs_seq #(
    parameter int unsigned MAX_PARTICLES = pdcfs_pkg::MAX_PARTICLES_DEF,
    parameter int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pdcfs_pkg::t_cfg                     i_cfg,
    pdcfs_in_if.sink                            in_ch,
    pdcfs_out_if.source                         out_ch,
    output logic                                o_st_we,
    output logic [AW-1:0]                       o_st_waddr,
    output pdcfs_pkg::t_part                    o_st_wdata,
    output logic [AW-1:0]                       o_st_raddr,
    input  pdcfs_pkg::t_part                    i_st_rdata,
    output logic signed [pdcfs_pkg::MUL_W-1:0]  o_mul_a,
    output logic signed [pdcfs_pkg::MUL_W-1:0]  o_mul_b,
    input  logic signed [pdcfs_pkg::PROD_W-1:0] i_mul_prod
);
    import pdcfs_pkg::*;

    localparam int unsigned NW = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_P0, S_P1, S_P2, S_P3, S_Q0, S_Q1, S_Q2, S_H, S_H2,
        S_T, S_T2, S_SC, S_V, S_SA, S_SB, S_SC2, S_SD, S_DONE
    } t_state;

    t_state                    r_state;
    logic [NW-1:0]             r_i;
    logic [NW-1:0]             r_n;
    logic signed [FIELD_W-1:0] r_kx, r_ky, r_kz;
    logic [31:0]               r_ph;
    logic                      r_pass;
    logic [30:0]               r_t;
    logic [30:0]               r_u;
    logic [31:0]               r_h;
    logic [1:0]                r_hk;
    logic [16:0]               r_st;
    logic signed [TRIG_W-1:0]  r_c, r_s;
    logic [2:0]                r_vj;
    logic signed [ACC_W-1:0]   r_acc [NUM_OUT];
    logic [2:0]                r_j;
    logic [ACC_W-1:0]          r_mag;
    logic                      r_neg;
    logic [24:0]               r_rr;
    logic                      r_sat;
    logic signed [OUT_W-1:0]   r_res [NUM_OUT];
    logic                      r_out_valid;

    logic                      in_acc;
    logic [NW-1:0]             n_cnt;
    logic [NW-1:0]             i_nxt;
    logic [35:0]               sv_sum;
    logic [16:0]               sv_val;
    logic [31:0]               h_nxt;
    logic signed [TRIG_W-1:0]  st_s, ct_s, c_q, s_q;
    logic signed [PROD_W-1:0]  term_sum;
    logic signed [ACC_W-1:0]   term;
    logic [47:0]               rr_sum;
    logic [49:0]               m_val;
    logic signed [OUT_W-1:0]   res_val;
    logic                      res_sat;
    logic signed [FIELD_W-1:0] v_sel;
    logic signed [TRIG_W-1:0]  t_sel;

    assign in_acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE);

    assign o_st_we    = in_acc && (in_ch.kind == KIND_LOAD)
                        && ({20'd0, in_ch.particle_index} < 32'(MAX_PARTICLES));
    assign o_st_waddr = AW'(in_ch.particle_index);
    assign o_st_wdata = '{in_ch.pos_x, in_ch.pos_y, in_ch.pos_z,
                          in_ch.vel_x, in_ch.vel_y, in_ch.vel_z};
    assign o_st_raddr = r_i[AW-1:0];

    always_comb begin
        if ({19'd0, i_cfg.particle_count} > 32'(MAX_PARTICLES)) begin
            n_cnt = NW'(MAX_PARTICLES);
        end else begin
            n_cnt = NW'(i_cfg.particle_count);
        end
    end

    assign i_nxt  = r_i + NW'(1);
    assign sv_sum = i_mul_prod[65:30] + 36'd8192;
    assign sv_val = sv_sum[30:14];
    assign h_nxt  = f_horner(r_hk) - i_mul_prod[61:30];

    // quadrant symmetries of the angle
    assign st_s = {1'b0, r_st};
    assign ct_s = {1'b0, sv_val};
    always_comb begin
        case (r_ph[31:30])
            2'd0:    begin s_q = st_s;  c_q = ct_s;  end
            2'd1:    begin s_q = ct_s;  c_q = -st_s; end
            2'd2:    begin s_q = -st_s; c_q = -ct_s; end
            default: begin s_q = -ct_s; c_q = st_s;  end
        endcase
    end

    // round trig*v from Q.28 to Q.16, half up
    assign term_sum = i_mul_prod + PROD_W'(2048);
    assign term     = term_sum[59:12];

    assign rr_sum = i_mul_prod[47:0] + 48'h40_0000;
    assign m_val  = i_mul_prod[49:0] + 50'(r_rr);

    always_comb begin
        res_sat = 1'b0;
        if (r_neg) begin
            if (m_val > 50'h8000_0000_0000) begin
                res_sat = 1'b1;
                res_val = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                res_val = -$signed(m_val[OUT_W-1:0]);
            end
        end else begin
            if (m_val > 50'h7FFF_FFFF_FFFF) begin
                res_sat = 1'b1;
                res_val = {1'b0, {(OUT_W-1){1'b1}}};
            end else begin
                res_val = $signed(m_val[OUT_W-1:0]);
            end
        end
    end

    always_comb begin
        case (r_vj)
            3'd0, 3'd1: v_sel = i_st_rdata.vel_x;
            3'd2, 3'd3: v_sel = i_st_rdata.vel_y;
            default:    v_sel = i_st_rdata.vel_z;
        endcase
        t_sel = r_vj[0] ? r_s : r_c;
    end

    always_comb begin
        o_mul_a = '0;
        o_mul_b = '0;
        case (r_state)
            S_P0: begin
                o_mul_a = {{9{r_kx[23]}}, r_kx};
                o_mul_b = {{9{i_st_rdata.pos_x[23]}}, i_st_rdata.pos_x};
            end
            S_P1: begin
                o_mul_a = {{9{r_ky[23]}}, r_ky};
                o_mul_b = {{9{i_st_rdata.pos_y[23]}}, i_st_rdata.pos_y};
            end
            S_P2: begin
                o_mul_a = {{9{r_kz[23]}}, r_kz};
                o_mul_b = {{9{i_st_rdata.pos_z[23]}}, i_st_rdata.pos_z};
            end
            S_Q1: begin
                o_mul_a = {2'b00, r_t};
                o_mul_b = {2'b00, r_t};
            end
            S_H: begin
                o_mul_a = {2'b00, r_u};
                o_mul_b = {1'b0, r_h};
            end
            // hold the operands so the cosine product is still there in S_SC
            S_T, S_T2: begin
                o_mul_a = {2'b00, r_t};
                o_mul_b = {1'b0, r_h};
            end
            S_V: begin
                o_mul_a = {{15{t_sel[17]}}, t_sel};
                o_mul_b = {{9{v_sel[23]}}, v_sel};
            end
            S_SB: begin
                o_mul_a = {10'd0, r_mag[22:0]};
                o_mul_b = {9'd0, i_cfg.scale_factor};
            end
            S_SC2: begin
                o_mul_a = {8'd0, r_mag[47:23]};
                o_mul_b = {9'd0, i_cfg.scale_factor};
            end
            default: begin
                o_mul_a = '0;
                o_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_n         <= '0;
            r_pass      <= 1'b0;
            r_hk        <= '0;
            r_vj        <= '0;
            r_j         <= '0;
            r_sat       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (in_ch.kind == KIND_QUERY)) begin
                        r_kx  <= in_ch.wave_x;
                        r_ky  <= in_ch.wave_y;
                        r_kz  <= in_ch.wave_z;
                        r_n   <= n_cnt;
                        r_i   <= '0;
                        r_j   <= '0;
                        r_sat <= 1'b0;
                        for (int k = 0; k < NUM_OUT; k++) begin
                            r_acc[k] <= '0;
                        end
                        r_state <= (n_cnt == '0) ? S_SA : S_RD;
                    end
                end
                S_RD: r_state <= S_P0;
                S_P0: r_state <= S_P1;
                S_P1: begin
                    r_ph    <= i_mul_prod[31:0];
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_ph    <= r_ph + i_mul_prod[31:0];
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_ph    <= r_ph + i_mul_prod[31:0];
                    r_pass  <= 1'b0;
                    r_state <= S_Q0;
                end
                S_Q0: begin
                    // cosine pass evaluates the sine at the complementary angle
                    r_t     <= r_pass ? (Q30_ONE - {1'b0, r_ph[29:0]}) : {1'b0, r_ph[29:0]};
                    r_state <= S_Q1;
                end
                S_Q1: r_state <= S_Q2;
                S_Q2: begin
                    r_u     <= i_mul_prod[60:30];
                    r_h     <= COEF_A9;
                    r_hk    <= '0;
                    r_state <= S_H;
                end
                S_H: r_state <= S_H2;
                S_H2: begin
                    r_h     <= h_nxt;
                    r_hk    <= r_hk + 2'd1;
                    r_state <= (r_hk == 2'd3) ? S_T : S_H;
                end
                S_T: r_state <= S_T2;
                S_T2: begin
                    if (!r_pass) begin
                        r_st    <= sv_val;
                        r_pass  <= 1'b1;
                        r_state <= S_Q0;
                    end else begin
                        r_state <= S_SC;
                    end
                end
                S_SC: begin
                    r_c      <= c_q;
                    r_s      <= s_q;
                    r_acc[0] <= r_acc[0] + ACC_W'(c_q);
                    r_acc[1] <= r_acc[1] + ACC_W'(s_q);
                    if (i_cfg.with_current) begin
                        r_vj    <= '0;
                        r_state <= S_V;
                    end else if (i_nxt == r_n) begin
                        r_state <= S_SA;
                    end else begin
                        r_i     <= i_nxt;
                        r_state <= S_RD;
                    end
                end
                S_V: begin
                    // issue term vj, fold in the product of term vj-1
                    if (r_vj != 3'd0) begin
                        r_acc[r_vj + 3'd1] <= r_acc[r_vj + 3'd1] + term;
                    end
                    if (r_vj == 3'd6) begin
                        if (i_nxt == r_n) begin
                            r_state <= S_SA;
                        end else begin
                            r_i     <= i_nxt;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_vj <= r_vj + 3'd1;
                    end
                end
                S_SA: begin
                    r_neg   <= r_acc[r_j][ACC_W-1];
                    r_mag   <= r_acc[r_j][ACC_W-1] ? -r_acc[r_j] : r_acc[r_j];
                    r_state <= S_SB;
                end
                S_SB: r_state <= S_SC2;
                S_SC2: begin
                    r_rr    <= rr_sum[47:23];
                    r_state <= S_SD;
                end
                S_SD: begin
                    r_res[r_j] <= res_val;
                    r_sat      <= r_sat | res_sat;
                    r_j        <= r_j + 3'd1;
                    if (r_j == 3'(NUM_OUT - 1)) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_SA;
                    end
                end
                S_DONE: begin
                    if (out_ch.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid        = r_out_valid;
    assign out_ch.density_re   = r_res[0];
    assign out_ch.density_im   = r_res[1];
    assign out_ch.current_x_re = r_res[2];
    assign out_ch.current_x_im = r_res[3];
    assign out_ch.current_y_re = r_res[4];
    assign out_ch.current_y_im = r_res[5];
    assign out_ch.current_z_re = r_res[6];
    assign out_ch.current_z_im = r_res[7];
    assign out_ch.saturated    = r_sat;
endmodule

/* design/particle_density_current_fourier_sum.sv */
`timescale 1ns / 1ps
// Density and current Fourier sum over stored particles. A load beat writes one
// store slot when its index is below MAX_PARTICLES. A query beat walks slots
// 0..n-1, n being particle_count clamped to MAX_PARTICLES, through a single
// shared 33x33 multiplier: phase and sine/cosine for each particle, plus the
// current terms when current sums are on, then scaling of the eight sums. The
// input is not ready during a query or while its result waits. Store contents
// are undefined until loaded. Depends on pdcfs_pkg, pdcfs_if, pdcfs_mul,
// pdcfs_store, pdcfs_seq.
module particle_density_current_fourier_sum #(
    parameter int unsigned MAX_PARTICLES = pdcfs_pkg::MAX_PARTICLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    pdcfs_in_if.sink                             i_in_ch,
    pdcfs_out_if.source                          o_out_ch,
    input  logic                                 i_cfg_we,
    input  logic [pdcfs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pdcfs_pkg::SCALE_W-1:0]        i_cfg_data
);
    import pdcfs_pkg::*;

    localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    t_cfg                     r_cfg;
    logic                     st_we;
    logic [AW-1:0]            st_waddr, st_raddr;
    t_part                    st_wdata, st_rdata;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.particle_count <= CNT_W'(1);
            r_cfg.scale_factor   <= SCALE_W'(8388608);
            r_cfg.with_current   <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COUNT:   r_cfg.particle_count <= i_cfg_data[CNT_W-1:0];
                CFG_SCALE:   r_cfg.scale_factor   <= i_cfg_data;
                CFG_CURRENT: r_cfg.with_current   <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    pdcfs_store #(.DEPTH(MAX_PARTICLES), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    pdcfs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    pdcfs_seq #(.MAX_PARTICLES(MAX_PARTICLES), .AW(AW)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .in_ch      (i_in_ch),
        .out_ch     (o_out_ch),
        .o_st_we    (st_we),
        .o_st_waddr (st_waddr),
        .o_st_wdata (st_wdata),
        .o_st_raddr (st_raddr),
        .i_st_rdata (st_rdata),
        .o_mul_a    (mul_a),
        .o_mul_b    (mul_b),
        .i_mul_prod (mul_prod)
    );
endmodule

/* design/pdcfs_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the Fourier sum block, bound to the top level.
// Depends on particle_density_current_fourier_sum.
module pdcfs_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_kind,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_sat
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_sat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sat))
        else $error("saturation flag changed while stalled");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind |=> !i_in_ready)
        else $error("input ready right after a query beat");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result waits");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_kind && !i_out_valid |=> !i_out_valid)
        else $error("result after a load beat");
endmodule

bind particle_density_current_fourier_sum pdcfs_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_in_kind   (i_in_ch.kind),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_sat   (o_out_ch.saturated)
);
